// ===== sv/multi_channel_pwm_duty_fader_top_assert.svh =====
// Assertion macros for the PWM duty fader checker.
// Depends on nothing; included by the checker file.
`ifndef MULTI_CHANNEL_PWM_DUTY_FADER_TOP_ASSERT_SVH
`define MULTI_CHANNEL_PWM_DUTY_FADER_TOP_ASSERT_SVH

// checked only out of reset
`define PWMF_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked during reset as well
`define PWMF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/pwmf_pkg.sv =====
// Shared constants, codes and types of the PWM duty fader.
// No dependencies; imported by every module of the block.
package pwmf_pkg;

    localparam int CHANNELS     = 8;
    localparam int STEP_TIME_MS = 10;
    localparam int DUTY_BITS    = 16;

    localparam int DW        = 16;
    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DIV_CNT_W = $clog2(DW);

    localparam logic [DW-1:0] DUTY_MASK =
        (DUTY_BITS >= DW) ? {DW{1'b1}} : DW'((64'd1 << DUTY_BITS) - 64'd1);

    // fade duration / STEP_TIME_MS by reciprocal, exact for any 16-bit duration
    localparam int    RECIP_SHIFT = DW + $clog2(STEP_TIME_MS);
    localparam longint RECIP      = ((64'd1 << RECIP_SHIFT) + STEP_TIME_MS - 1) / STEP_TIME_MS;
    localparam int    RECIP_W     = $clog2(RECIP + 1);
    localparam int    PROD_W      = DW + RECIP_W;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 24;

    typedef logic [2:0] mode_t;
    localparam mode_t MODE_LOAD     = 3'd0;
    localparam mode_t MODE_SET_IMM  = 3'd1;
    localparam mode_t MODE_SET_FADE = 3'd2;
    localparam mode_t MODE_START    = 3'd3;
    localparam mode_t MODE_TICK     = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DIV,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic take;
        logic div_init;
        logic div_step;
        logic exec;
        logic next_ch;
    } dp_cmd_t;

    typedef struct packed {
        logic item_ok;
        logic is_fade;
        logic is_tick;
        logic out_free;
        logic last_ch;
    } dp_stat_t;

endpackage

// ===== sv/multi_channel_pwm_duty_fader_top.sv =====
// Top level of the PWM duty fader: joins controller and datapath.
// Depends on pwmf_pkg, pwmf_ctrl and pwmf_dp.
//
//  port group   direction  beats per item
//  s_*          in         1
//  m_*          out        1 (modes 0..3), CHANNELS (tick), 0 (ignored)
//
// Load, immediate target and start pass through capture, decode and update; a fade target
// also runs the bit-serial divider between decode and update. A tick updates the channels
// in turn, one per channel, through the single state read port.
// aresetn clears all channel state. A stalled m_ side holds the next update.
module multi_channel_pwm_duty_fader_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // channel[2:0], duty_value[18:3], fade_ms[34:19]
    input  logic [2:0]  s_tuser,  // mode[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,  // out_channel[2:0], out_duty[18:3], fading[19]
    output logic        m_tlast
);
    import pwmf_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    pwmf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pwmf_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tlast  (m_tlast),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

// ===== sv/pwmf_ctrl.sv =====
// Controller FSM of the PWM duty fader: sequences capture, division and update.
// Depends on pwmf_pkg.
module pwmf_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  pwmf_pkg::dp_stat_t stat,
    output pwmf_pkg::dp_cmd_t  cmd
);
    import pwmf_pkg::*;

    state_t               state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                cnt_next = '0;
                if (!stat.item_ok) begin
                    state_next = ST_IDLE;
                end else if (stat.is_fade) begin
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_EXEC;
                end
            end
            ST_DIV: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DW - 1)) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (stat.out_free && (!stat.is_tick || stat.last_ch)) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.take = s_tvalid;
            end
            ST_DECODE: begin
                cmd.div_init = stat.item_ok && stat.is_fade;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
            end
            ST_EXEC: begin
                cmd.exec    = stat.out_free;
                cmd.next_ch = stat.out_free && stat.is_tick && !stat.last_ch;
            end
            default: ;
        endcase
    end

endmodule

// ===== sv/pwmf_dp.sv =====
// Datapath of the PWM duty fader: channel state, serial divider, output register.
// Depends on pwmf_pkg.
module pwmf_dp (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [pwmf_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic [2:0]                         s_tuser,
    output logic [pwmf_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                               m_tvalid,
    output logic                               m_tlast,
    input  logic                               m_tready,
    input  pwmf_pkg::dp_cmd_t                  cmd,
    output pwmf_pkg::dp_stat_t                 stat
);
    import pwmf_pkg::*;

    logic [DW-1:0] cur_reg  [CHANNELS];
    logic [DW-1:0] tgt_reg  [CHANNELS];
    logic [DW-1:0] step_reg [CHANNELS];
    logic          act_reg  [CHANNELS];

    mode_t         mode_reg;
    logic [2:0]    ch_reg;
    logic [DW-1:0] duty_reg;
    logic [DW-1:0] fade_reg;
    logic [CH_W-1:0] idx_reg;

    logic [DW-1:0] rem_reg, quo_reg, den_reg;

    logic          out_valid_reg;
    logic [CH_W-1:0] out_ch_reg;
    logic [DW-1:0] out_duty_reg;
    logic          out_fading_reg;
    logic          out_last_reg;

    logic [DW-1:0] cur, tgt, st, diff, duty_m;
    logic          act;
    logic [DW-1:0] cur_next, tgt_next, step_next;
    logic          act_next;
    logic [PROD_W-1:0] prod;
    logic [DW-1:0] ticks;
    logic [DW:0]   shifted;
    logic          fits;

    assign cur    = cur_reg[idx_reg];
    assign tgt    = tgt_reg[idx_reg];
    assign act    = act_reg[idx_reg];
    assign st     = (step_reg[idx_reg] == '0) ? DW'(1) : step_reg[idx_reg];
    assign duty_m = duty_reg & DUTY_MASK;
    assign diff   = (cur > duty_m) ? (cur - duty_m) : (duty_m - cur);

    assign prod  = PROD_W'(fade_reg) * PROD_W'(RECIP);
    assign ticks = (DW'(prod >> RECIP_SHIFT) == '0) ? DW'(1) : DW'(prod >> RECIP_SHIFT);

    assign shifted = {rem_reg, quo_reg[DW-1]};
    assign fits    = shifted >= {1'b0, den_reg};

    always_comb begin
        cur_next  = cur;
        tgt_next  = tgt;
        step_next = step_reg[idx_reg];
        act_next  = act;
        case (mode_reg)
            MODE_LOAD: cur_next = duty_m;
            MODE_SET_IMM: begin
                tgt_next  = duty_m;
                step_next = (diff == '0) ? DW'(1) : diff;
            end
            MODE_SET_FADE: begin
                tgt_next  = duty_m;
                step_next = (quo_reg == '0) ? DW'(1) : quo_reg;
            end
            MODE_START: act_next = 1'b1;
            MODE_TICK: begin
                if (act) begin
                    if (cur < tgt) begin
                        cur_next = ((tgt - cur) > st) ? (cur + st) : tgt;
                    end else if (cur > tgt) begin
                        cur_next = ((cur - tgt) > st) ? (cur - st) : tgt;
                    end
                    act_next = (cur_next != tgt);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                cur_reg[i]  <= '0;
                tgt_reg[i]  <= '0;
                step_reg[i] <= '0;
                act_reg[i]  <= 1'b0;
            end
        end else if (cmd.exec) begin
            cur_reg[idx_reg]  <= cur_next;
            tgt_reg[idx_reg]  <= tgt_next;
            step_reg[idx_reg] <= step_next;
            act_reg[idx_reg]  <= act_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            mode_reg <= s_tuser;
            ch_reg   <= s_tdata[2:0];
            duty_reg <= s_tdata[18:3];
            fade_reg <= s_tdata[34:19];
            idx_reg  <= (s_tuser == MODE_TICK) ? '0 : CH_W'(s_tdata[2:0]);
        end else if (cmd.next_ch) begin
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.div_init) begin
            rem_reg <= '0;
            quo_reg <= diff;
            den_reg <= ticks;
        end else if (cmd.div_step) begin
            rem_reg <= fits ? DW'(shifted - {1'b0, den_reg}) : DW'(shifted);
            quo_reg <= {quo_reg[DW-2:0], fits};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.exec) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            out_ch_reg     <= idx_reg;
            out_duty_reg   <= cur_next;
            out_fading_reg <= act_next;
            out_last_reg   <= (mode_reg != MODE_TICK) || stat.last_ch;
        end
    end

    assign stat.item_ok  = (mode_reg == MODE_TICK) ||
                           ((mode_reg < MODE_TICK) && (32'(ch_reg) < CHANNELS));
    assign stat.is_fade  = (mode_reg == MODE_SET_FADE);
    assign stat.is_tick  = (mode_reg == MODE_TICK);
    assign stat.out_free = !out_valid_reg || m_tready;
    assign stat.last_ch  = (idx_reg == CH_W'(CHANNELS - 1));

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {4'b0, out_fading_reg, out_duty_reg, 3'(out_ch_reg)};

endmodule

// ===== sv/pwmf_checker.sv =====
// Port-level checker for the PWM duty fader, bound to the top level.
// Depends on pwmf_pkg and multi_channel_pwm_duty_fader_top_assert.svh.
`include "multi_channel_pwm_duty_fader_top_assert.svh"

module pwmf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);
    import pwmf_pkg::*;

    `PWMF_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result beat changed")
    `PWMF_ASSERT_ALWAYS(a_reset_quiet, aclk, !aresetn |=> !m_tvalid, "result beat straight after reset")
    `PWMF_ASSERT(a_busy_after_in, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "input taken while an item is in work")
    `PWMF_ASSERT(a_ch_range, aclk, aresetn, m_tvalid |-> 32'(m_tdata[2:0]) < CHANNELS, "result for a channel that does not exist")

endmodule

bind multi_channel_pwm_duty_fader_top pwmf_checker u_pwmf_checker (.*);

// ===== bench/tb_multi_channel_pwm_duty_fader_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for multi_channel_pwm_duty_fader_top: directed and random
// load, target, start, tick and unused-mode beats, with results checked against a local fader model.
// Depends on pwmf_pkg and the top-level RTL only.
module tb_multi_channel_pwm_duty_fader_top;
    import pwmf_pkg::*;

    typedef struct {
        mode_t       mode;
        logic [2:0]  ch;
        logic [15:0] duty;
        logic [15:0] ftime;
    } fade_cmd_t;

    typedef struct {
        logic [2:0]  ch;
        logic [15:0] duty;
        logic        fading;
        logic        last;
    } duty_report_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [23:0] m_tdata;
    logic        m_tlast;

    multi_channel_pwm_duty_fader_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    fade_cmd_t    pending_cmds[$];
    duty_report_t duty_reports_due[$];

    logic [15:0] duty_now [CHANNELS];
    logic [15:0] duty_goal[CHANNELS];
    logic [15:0] duty_step[CHANNELS];
    logic        moving   [CHANNELS];

    int  mismatches = 0;
    int  live_cmds  = 0;
    int  s_wait = 0, s_calm = 0, m_wait = 0, m_calm = 0;
    bit  s_taken = 1'b0, m_taken = 1'b0;
    bit  drain = 1'b0;

    initial begin
        for (int i = 0; i < CHANNELS; i++) begin
            duty_now[i]  = '0;
            duty_goal[i] = '0;
            duty_step[i] = '0;
            moving[i]    = 1'b0;
        end
    end

    function automatic int draw_gap(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    function automatic logic [15:0] sat_step(int s);
        if (s == 0)
            return 16'd1;
        if (s > 65535)
            return 16'hFFFF;
        return 16'(s);
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(string name, int got, int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    task automatic push_report(int ch, logic last);
        duty_report_t r;
        r.ch     = 3'(ch);
        r.duty   = duty_now[ch];
        r.fading = moving[ch];
        r.last   = last;
        duty_reports_due.push_back(r);
    endtask

    // advance the channel model by one accepted beat and queue its reports
    task automatic fader_predict(fade_cmd_t c);
        int now, goal, st, diff, ticks;
        logic [15:0] d;
        d = c.duty & DUTY_MASK;
        if (c.mode == MODE_TICK) begin
            for (int i = 0; i < CHANNELS; i++) begin
                if (moving[i]) begin
                    now  = int'(duty_now[i]);
                    goal = int'(duty_goal[i]);
                    st   = (duty_step[i] == 0) ? 1 : int'(duty_step[i]);
                    if (now < goal)
                        now = (goal - now > st) ? now + st : goal;
                    else if (now > goal)
                        now = (now - goal > st) ? now - st : goal;
                    duty_now[i] = 16'(now);
                    moving[i]   = (now != goal);
                end
            end
            for (int i = 0; i < CHANNELS; i++)
                push_report(i, i == CHANNELS - 1);
        end else if (c.mode < MODE_TICK && int'(c.ch) < CHANNELS) begin
            now  = int'(duty_now[c.ch]);
            diff = (now > int'(d)) ? now - int'(d) : int'(d) - now;
            case (c.mode)
                MODE_LOAD: begin
                    duty_now[c.ch] = d;
                end
                MODE_SET_IMM: begin
                    duty_goal[c.ch] = d;
                    duty_step[c.ch] = sat_step(diff);
                end
                MODE_SET_FADE: begin
                    duty_goal[c.ch] = d;
                    ticks = int'(c.ftime) / STEP_TIME_MS;
                    if (ticks == 0)
                        ticks = 1;
                    duty_step[c.ch] = sat_step(diff / ticks);
                end
                default: begin
                    moving[c.ch] = 1'b1;
                end
            endcase
            push_report(int'(c.ch), 1'b1);
        end
    endtask

    task automatic queue_cmd(mode_t mode, logic [2:0] ch, logic [15:0] duty,
                             logic [15:0] ftime);
        fade_cmd_t c;
        c.mode  = mode;
        c.ch    = ch;
        c.duty  = duty;
        c.ftime = ftime;
        pending_cmds.push_back(c);
        if (mode <= MODE_TICK)
            live_cmds++;
    endtask

    // beat monitor and predictor
    always @(posedge aclk) begin : monitor
        duty_report_t got, want;
        fade_cmd_t    cmd;
        if (!aresetn) begin
            s_taken <= 1'b0;
            m_taken <= 1'b0;
        end else begin
            s_taken <= s_tvalid && s_tready;
            m_taken <= m_tvalid && m_tready;
            if (m_tvalid && m_tready) begin
                got.ch     = m_tdata[2:0];
                got.duty   = m_tdata[18:3];
                got.fading = m_tdata[19];
                got.last   = m_tlast;
                if (duty_reports_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat, channel %0d duty %0d",
                                              got.ch, got.duty));
                end else begin
                    want = duty_reports_due.pop_front();
                    check_field("out_channel", int'(got.ch), int'(want.ch));
                    check_field("out_duty", int'(got.duty), int'(want.duty));
                    check_field("fading", int'(got.fading), int'(want.fading));
                    check_field("last", int'(got.last), int'(want.last));
                end
            end
            if (s_tvalid && s_tready) begin
                cmd.mode  = s_tuser;
                cmd.ch    = s_tdata[2:0];
                cmd.duty  = s_tdata[18:3];
                cmd.ftime = s_tdata[34:19];
                fader_predict(cmd);
            end
        end
    end

    // input driver
    always @(negedge aclk) begin : driver
        fade_cmd_t c;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!(s_tvalid && !s_taken)) begin
            if (s_tvalid)
                s_wait = draw_gap(s_calm);
            if (s_wait > 0 || pending_cmds.size() == 0) begin
                s_tvalid <= 1'b0;
                if (s_wait > 0)
                    s_wait--;
            end else begin
                c = pending_cmds.pop_front();
                s_tdata  <= {5'b0, c.ftime, c.duty, c.ch};
                s_tuser  <= c.mode;
                s_tvalid <= 1'b1;
            end
        end
    end

    // result-side back-pressure
    always @(negedge aclk) begin
        if (drain) begin
            m_tready <= 1'b1;
        end else begin
            if (m_taken)
                m_wait = draw_gap(m_calm);
            if (m_wait > 0) begin
                m_tready <= 1'b0;
                m_wait--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int kind;
        logic [2:0] ch;
        logic [15:0] ft;

        // directed: reset state, extremes and the awkward cases
        queue_cmd(MODE_TICK, 3'd0, 16'h0000, 16'h0000);
        queue_cmd(MODE_LOAD, 3'd0, 16'hFFFF, 16'hFFFF);
        queue_cmd(MODE_SET_IMM, 3'd0, 16'h0000, 16'h0000);
        queue_cmd(MODE_START, 3'd0, 16'h0000, 16'h0000);
        queue_cmd(MODE_LOAD, 3'd1, 16'h0000, 16'h0000);
        queue_cmd(MODE_SET_FADE, 3'd1, 16'hFFFF, 16'h0000);   // fade time below one tick
        queue_cmd(MODE_START, 3'd1, 16'h0000, 16'h0000);
        queue_cmd(MODE_LOAD, 3'd2, 16'd100, 16'h0000);
        queue_cmd(MODE_SET_FADE, 3'd2, 16'd105, 16'hFFFF);    // step rounds to zero
        queue_cmd(MODE_START, 3'd2, 16'h0000, 16'h0000);
        queue_cmd(MODE_LOAD, 3'd3, 16'd500, 16'h0000);
        queue_cmd(MODE_SET_IMM, 3'd3, 16'd500, 16'h0000);     // already at target
        queue_cmd(MODE_START, 3'd3, 16'h0000, 16'h0000);
        queue_cmd(MODE_LOAD, 3'd4, 16'd1000, 16'h0000);
        queue_cmd(MODE_SET_FADE, 3'd4, 16'd0, 16'd30);        // overshoot on last step
        queue_cmd(MODE_START, 3'd4, 16'h0000, 16'h0000);
        queue_cmd(MODE_TICK, 3'd7, 16'hFFFF, 16'hFFFF);
        queue_cmd(MODE_SET_FADE, 3'd2, 16'd50, 16'd20);       // retarget mid-fade
        queue_cmd(MODE_TICK, 3'd0, 16'h0000, 16'h0000);
        queue_cmd(MODE_SET_FADE, 3'd7, 16'h8000, 16'd9);
        queue_cmd(MODE_START, 3'd7, 16'h0000, 16'h0000);
        queue_cmd(mode_t'(5), 3'd5, 16'hFFFF, 16'hFFFF);
        queue_cmd(mode_t'(6), 3'd6, 16'h5555, 16'hAAAA);
        queue_cmd(mode_t'(7), 3'd7, 16'hAAAA, 16'h5555);
        repeat (3) queue_cmd(MODE_TICK, 3'd0, 16'h0000, 16'h0000);

        live_cmds = 0;
        while (live_cmds < 280) begin
            kind = $urandom_range(0, 9);
            ch   = 3'($urandom_range(0, 7));
            ft   = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 120));
            if (kind <= 5) begin
                if ($urandom_range(0, 1) == 1)
                    queue_cmd(MODE_LOAD, ch, 16'($urandom), 16'($urandom));
                if ($urandom_range(0, 3) == 0)
                    queue_cmd(MODE_SET_IMM, ch, 16'($urandom), 16'($urandom));
                else
                    queue_cmd(MODE_SET_FADE, ch, 16'($urandom), ft);
                queue_cmd(MODE_START, ch, 16'($urandom), 16'($urandom));
                repeat ($urandom_range(1, 6))
                    queue_cmd(MODE_TICK, 3'($urandom), 16'($urandom), 16'($urandom));
            end else if (kind <= 7) begin
                repeat ($urandom_range(1, 4))
                    queue_cmd(MODE_TICK, 3'($urandom), 16'($urandom), 16'($urandom));
            end else if (kind == 8) begin
                queue_cmd(mode_t'($urandom_range(0, 7)), ch, 16'($urandom), 16'($urandom));
            end else begin
                // half a sequence: start or target alone
                if ($urandom_range(0, 1) == 1)
                    queue_cmd(MODE_START, ch, 16'($urandom), 16'($urandom));
                else
                    queue_cmd(MODE_SET_FADE, ch, 16'($urandom), ft);
            end
        end

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_cmds.size() != 0 || s_tvalid || duty_reports_due.size() != 0)
            @(posedge aclk);
        drain = 1'b1;
        repeat (40) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        #4000000;
        $display("Verification failed");
        $finish;
    end

endmodule
